// ===== design/dktm_pkg.sv =====
`default_nettype none

package dktm_pkg;

    // field widths
    localparam int IDX_W      = 12;
    localparam int DATA_W     = 32;
    localparam int ROWLEN_W   = 12;
    localparam int LINE_W     = 13;
    localparam int PLANE_W    = 21;
    localparam int COMP_W     = 3;
    localparam int NCOMP      = 6;
    localparam int FRAC_W     = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 21;

    // default kernel store depth
    localparam int KERNEL_ENTRIES_DEF = 4096;

    // register map
    localparam logic [CFG_IDX_W-1:0] REG_ROW_LENGTH   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LINE_Y       = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LINE_Z       = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_PLANE_STRIDE = 2'd3;

    // beat kinds
    localparam logic ACT_LOAD = 1'b0;
    localparam logic ACT_MUL  = 1'b1;

    // tensor components
    localparam logic [COMP_W-1:0] COMP_XX = 3'd0;
    localparam logic [COMP_W-1:0] COMP_YY = 3'd1;
    localparam logic [COMP_W-1:0] COMP_ZZ = 3'd2;
    localparam logic [COMP_W-1:0] COMP_XY = 3'd3;
    localparam logic [COMP_W-1:0] COMP_XZ = 3'd4;
    localparam logic [COMP_W-1:0] COMP_YZ = 3'd5;

    // tensor row r, column j -> stored component
    localparam logic [COMP_W-1:0] ROW_COMP [3][3] = '{
        '{COMP_XX, COMP_XY, COMP_XZ},
        '{COMP_XY, COMP_YY, COMP_YZ},
        '{COMP_XZ, COMP_YZ, COMP_ZZ}
    };

endpackage

`default_nettype wire

// ===== design/dktm_ram.sv =====
`default_nettype none

module dktm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4096
) (
    input  wire logic                                   aclk,
    input  wire logic                                   wr_en,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]                       wr_data,
    input  wire logic                                   rd_en,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic      [WIDTH-1:0]                       rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// ===== design/demag_kernel_tensor_multiply_top.sv =====
`default_nettype none

// channel  direction  handshake                 payload
// s_       in         s_valid / s_ready         action, x/y/z index, m vector, kernel load
// m_       out        m_valid / m_ready         h vector, saturated, out_of_range
// cfg_     in         cfg_valid / cfg_ready     cfg_index, cfg_data (always ready)
//
// one beat per cycle sustained while m_ready stays high; a multiply beat passes every stage on its way to m_
// eight register stages: input, fold, address multiply, address add + store access,
// sign fix, tensor multiply, sum, saturate into the output register
// load beats write the kernel store at stage 3 and produce nothing
// aresetn is synchronous, clears the valid bits and sets the config registers to 1
// each stage holds while its successor is full and stalled; ready ripples back from m_ready

module demag_kernel_tensor_multiply_top #(
    parameter int KERNEL_ENTRIES = dktm_pkg::KERNEL_ENTRIES_DEF
) (
    input  wire logic                                   aclk,
    input  wire logic                                   aresetn,

    input  wire logic                                   cfg_valid,
    output logic                                        cfg_ready,
    input  wire logic [dktm_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  wire logic [dktm_pkg::CFG_DATA_W-1:0]        cfg_data,

    input  wire logic                                   s_valid,
    output logic                                        s_ready,
    input  wire logic                                   s_action,
    input  wire logic [dktm_pkg::IDX_W-1:0]             s_x_index,
    input  wire logic [dktm_pkg::IDX_W-1:0]             s_y_index,
    input  wire logic [dktm_pkg::IDX_W-1:0]             s_z_index,
    input  wire logic signed [dktm_pkg::DATA_W-1:0]     s_mx_re,
    input  wire logic signed [dktm_pkg::DATA_W-1:0]     s_mx_im,
    input  wire logic signed [dktm_pkg::DATA_W-1:0]     s_my_re,
    input  wire logic signed [dktm_pkg::DATA_W-1:0]     s_my_im,
    input  wire logic signed [dktm_pkg::DATA_W-1:0]     s_mz_re,
    input  wire logic signed [dktm_pkg::DATA_W-1:0]     s_mz_im,
    input  wire logic [dktm_pkg::COMP_W-1:0]            s_kernel_component,
    input  wire logic signed [dktm_pkg::DATA_W-1:0]     s_kernel_value,

    output logic                                        m_valid,
    input  wire logic                                   m_ready,
    output logic signed [dktm_pkg::DATA_W-1:0]          m_hx_re,
    output logic signed [dktm_pkg::DATA_W-1:0]          m_hx_im,
    output logic signed [dktm_pkg::DATA_W-1:0]          m_hy_re,
    output logic signed [dktm_pkg::DATA_W-1:0]          m_hy_im,
    output logic signed [dktm_pkg::DATA_W-1:0]          m_hz_re,
    output logic signed [dktm_pkg::DATA_W-1:0]          m_hz_im,
    output logic                                        m_saturated,
    output logic                                        m_out_of_range
);

    localparam int AW      = (KERNEL_ENTRIES > 1) ? $clog2(KERNEL_ENTRIES) : 1;
    localparam int IW      = dktm_pkg::IDX_W;
    localparam int DW      = dktm_pkg::DATA_W;
    localparam int NC      = dktm_pkg::NCOMP;
    localparam int PY_W    = IW + dktm_pkg::ROWLEN_W;      // ry * row_length
    localparam int PZ_W    = IW + dktm_pkg::PLANE_W;       // rz * plane_stride
    localparam int ADDR_W  = PZ_W + 1;                     // x + py + pz
    localparam int K_W     = DW + 1;                       // kernel after negation
    localparam int P_W     = K_W + DW;                     // one product
    localparam int S_W     = P_W + 2;                      // sum of three products
    localparam int SH_W    = S_W - dktm_pkg::FRAC_W;       // sum after the fraction shift

    // ------------------------------------------------------------------
    // configuration registers, to be written only while idle (the block does not enforce it)
    // ------------------------------------------------------------------
    logic [dktm_pkg::ROWLEN_W-1:0] row_length_reg;
    logic [dktm_pkg::LINE_W-1:0]   line_y_reg;
    logic [dktm_pkg::LINE_W-1:0]   line_z_reg;
    logic [dktm_pkg::PLANE_W-1:0]  plane_stride_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_length_reg   <= dktm_pkg::ROWLEN_W'(1);
            line_y_reg       <= dktm_pkg::LINE_W'(1);
            line_z_reg       <= dktm_pkg::LINE_W'(1);
            plane_stride_reg <= dktm_pkg::PLANE_W'(1);
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                dktm_pkg::REG_ROW_LENGTH:   row_length_reg   <= cfg_data[dktm_pkg::ROWLEN_W-1:0];
                dktm_pkg::REG_LINE_Y:       line_y_reg       <= cfg_data[dktm_pkg::LINE_W-1:0];
                dktm_pkg::REG_LINE_Z:       line_z_reg       <= cfg_data[dktm_pkg::LINE_W-1:0];
                dktm_pkg::REG_PLANE_STRIDE: plane_stride_reg <= cfg_data[dktm_pkg::PLANE_W-1:0];
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // stage valid bits and the ready chain
    // ------------------------------------------------------------------
    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg, v6_reg, v7_reg, vo_reg;
    logic rdy1, rdy2, rdy3, rdy4, rdy5, rdy6, rdy7, rdyo;

    // a stage takes a new beat when it is empty or its content moves on
    assign rdyo = !vo_reg || m_ready;
    assign rdy7 = !v7_reg || rdyo;
    assign rdy6 = !v6_reg || rdy7;
    assign rdy5 = !v5_reg || rdy6;
    assign rdy4 = !v4_reg || rdy5;
    assign rdy3 = !v3_reg || rdy4;
    assign rdy2 = !v2_reg || rdy3;
    assign rdy1 = !v1_reg || rdy2;

    assign s_ready = rdy1;
    assign m_valid = vo_reg;

    // ------------------------------------------------------------------
    // stage 1: registered input beat
    // ------------------------------------------------------------------
    logic                  act1_reg;
    logic [IW-1:0]         x1_reg, y1_reg, z1_reg;
    logic signed [DW-1:0]  mre1_reg [3];
    logic signed [DW-1:0]  mim1_reg [3];
    logic [dktm_pkg::COMP_W-1:0] comp1_reg;
    logic [DW-1:0]         kval1_reg;

    always_ff @(posedge aclk) begin
        if (rdy1) begin
            act1_reg    <= s_action;
            x1_reg      <= s_x_index;
            y1_reg      <= s_y_index;
            z1_reg      <= s_z_index;
            mre1_reg[0] <= s_mx_re;
            mre1_reg[1] <= s_my_re;
            mre1_reg[2] <= s_mz_re;
            mim1_reg[0] <= s_mx_im;
            mim1_reg[1] <= s_my_im;
            mim1_reg[2] <= s_mz_im;
            comp1_reg   <= s_kernel_component;
            kval1_reg   <= s_kernel_value;
        end
    end

    // fold y and z above their half points; loads use the raw position
    logic                     is_mul1, ny1, nz1, oor_pos1;
    logic [IW-1:0]            ry1, rz1;
    logic [dktm_pkg::LINE_W-1:0] y1_ext, z1_ext;

    always_comb begin
        is_mul1  = (act1_reg == dktm_pkg::ACT_MUL);
        y1_ext   = {1'b0, y1_reg};
        z1_ext   = {1'b0, z1_reg};
        ny1      = is_mul1 && (y1_ext > (line_y_reg >> 1));
        nz1      = is_mul1 && (z1_ext > (line_z_reg >> 1));
        ry1      = ny1 ? IW'(line_y_reg - y1_ext) : y1_reg;
        rz1      = nz1 ? IW'(line_z_reg - z1_ext) : z1_reg;
        oor_pos1 = is_mul1 && ((x1_reg >= row_length_reg) ||
                               (y1_ext >= line_y_reg) ||
                               (z1_ext >= line_z_reg));
    end

    // ------------------------------------------------------------------
    // stage 2: folded position, address multiplies
    // ------------------------------------------------------------------
    logic                  act2_reg, ny2_reg, nz2_reg, oor2_reg;
    logic [IW-1:0]         x2_reg, ry2_reg, rz2_reg;
    logic signed [DW-1:0]  mre2_reg [3];
    logic signed [DW-1:0]  mim2_reg [3];
    logic [dktm_pkg::COMP_W-1:0] comp2_reg;
    logic [DW-1:0]         kval2_reg;

    always_ff @(posedge aclk) begin
        if (rdy2) begin
            act2_reg  <= act1_reg;
            ny2_reg   <= ny1;
            nz2_reg   <= nz1;
            oor2_reg  <= oor_pos1;
            x2_reg    <= x1_reg;
            ry2_reg   <= ry1;
            rz2_reg   <= rz1;
            mre2_reg  <= mre1_reg;
            mim2_reg  <= mim1_reg;
            comp2_reg <= comp1_reg;
            kval2_reg <= kval1_reg;
        end
    end

    logic [PY_W-1:0] py2;
    logic [PZ_W-1:0] pz2;

    assign py2 = PY_W'(ry2_reg) * PY_W'(row_length_reg);
    assign pz2 = PZ_W'(rz2_reg) * PZ_W'(plane_stride_reg);

    // ------------------------------------------------------------------
    // stage 3: address add, range check, kernel store access
    // ------------------------------------------------------------------
    logic                  act3_reg, ny3_reg, nz3_reg, oor3_reg;
    logic [IW-1:0]         x3_reg;
    logic [PY_W-1:0]       py3_reg;
    logic [PZ_W-1:0]       pz3_reg;
    logic signed [DW-1:0]  mre3_reg [3];
    logic signed [DW-1:0]  mim3_reg [3];
    logic [dktm_pkg::COMP_W-1:0] comp3_reg;
    logic [DW-1:0]         kval3_reg;

    always_ff @(posedge aclk) begin
        if (rdy3) begin
            act3_reg  <= act2_reg;
            ny3_reg   <= ny2_reg;
            nz3_reg   <= nz2_reg;
            oor3_reg  <= oor2_reg;
            x3_reg    <= x2_reg;
            py3_reg   <= py2;
            pz3_reg   <= pz2;
            mre3_reg  <= mre2_reg;
            mim3_reg  <= mim2_reg;
            comp3_reg <= comp2_reg;
            kval3_reg <= kval2_reg;
        end
    end

    logic [ADDR_W-1:0] addr3;
    logic              in_store3, is_mul3, move3, oor_all3;
    logic              ram_re;
    logic [NC-1:0]     ram_we;
    logic [DW-1:0]     kraw [NC];

    always_comb begin
        addr3     = ADDR_W'(x3_reg) + ADDR_W'(py3_reg) + ADDR_W'(pz3_reg);
        in_store3 = (addr3 < ADDR_W'(KERNEL_ENTRIES));
        is_mul3   = (act3_reg == dktm_pkg::ACT_MUL);
        move3     = v3_reg && rdy4;
        oor_all3  = oor3_reg || !in_store3;
        ram_re    = move3 && is_mul3 && !oor_all3;
    end

    // one 32-bit lane per tensor component, so a load touches at most one lane
    for (genvar i = 0; i < NC; i++) begin : g_lane
        assign ram_we[i] = move3 && !is_mul3 && in_store3 &&
                           (comp3_reg == dktm_pkg::COMP_W'(i));

        dktm_ram #(
            .WIDTH (DW),
            .DEPTH (KERNEL_ENTRIES)
        ) u_lane (
            .aclk    (aclk),
            .wr_en   (ram_we[i]),
            .wr_addr (addr3[AW-1:0]),
            .wr_data (kval3_reg),
            .rd_en   (ram_re),
            .rd_addr (addr3[AW-1:0]),
            .rd_data (kraw[i])
        );
    end

    // ------------------------------------------------------------------
    // stage 4: kernel words arrive, odd-symmetry sign fix
    // ------------------------------------------------------------------
    logic                  ny4_reg, nz4_reg, oor4_reg;
    logic signed [DW-1:0]  mre4_reg [3];
    logic signed [DW-1:0]  mim4_reg [3];

    always_ff @(posedge aclk) begin
        if (rdy4) begin
            ny4_reg  <= ny3_reg;
            nz4_reg  <= nz3_reg;
            oor4_reg <= oor_all3;
            mre4_reg <= mre3_reg;
            mim4_reg <= mim3_reg;
        end
    end

    logic signed [K_W-1:0] ks4 [NC];

    always_comb begin
        for (int i = 0; i < NC; i++) begin
            ks4[i] = K_W'($signed(kraw[i]));
        end
        // xy odd in y, xz odd in z, yz odd in both
        if (ny4_reg) begin
            ks4[dktm_pkg::COMP_XY] = -ks4[dktm_pkg::COMP_XY];
        end
        if (nz4_reg) begin
            ks4[dktm_pkg::COMP_XZ] = -ks4[dktm_pkg::COMP_XZ];
        end
        if (ny4_reg != nz4_reg) begin
            ks4[dktm_pkg::COMP_YZ] = -ks4[dktm_pkg::COMP_YZ];
        end
    end

    // ------------------------------------------------------------------
    // stage 5: signed kernel, eighteen multiplies
    // ------------------------------------------------------------------
    logic                  oor5_reg;
    logic signed [K_W-1:0] k5_reg [NC];
    logic signed [DW-1:0]  mre5_reg [3];
    logic signed [DW-1:0]  mim5_reg [3];

    always_ff @(posedge aclk) begin
        if (rdy5) begin
            oor5_reg <= oor4_reg;
            k5_reg   <= ks4;
            mre5_reg <= mre4_reg;
            mim5_reg <= mim4_reg;
        end
    end

    logic signed [P_W-1:0] prod5 [3][2][3];

    always_comb begin
        for (int r = 0; r < 3; r++) begin
            for (int j = 0; j < 3; j++) begin
                prod5[r][0][j] = k5_reg[dktm_pkg::ROW_COMP[r][j]] * mre5_reg[j];
                prod5[r][1][j] = k5_reg[dktm_pkg::ROW_COMP[r][j]] * mim5_reg[j];
            end
        end
    end

    // ------------------------------------------------------------------
    // stage 6: products, three-way sums and the fraction shift
    // ------------------------------------------------------------------
    logic                  oor6_reg;
    logic signed [P_W-1:0] prod6_reg [3][2][3];

    always_ff @(posedge aclk) begin
        if (rdy6) begin
            oor6_reg  <= oor5_reg;
            prod6_reg <= prod5;
        end
    end

    // the fraction shift floors the exact three-way sum once
    logic signed [S_W-1:0]  sum6 [3][2];
    logic signed [SH_W-1:0] sh6  [3][2];

    always_comb begin
        for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 2; c++) begin
                sum6[r][c] = S_W'(prod6_reg[r][c][0]) + S_W'(prod6_reg[r][c][1]) +
                             S_W'(prod6_reg[r][c][2]);
                sh6[r][c]  = SH_W'(sum6[r][c] >>> dktm_pkg::FRAC_W);
            end
        end
    end

    // ------------------------------------------------------------------
    // stage 7: shifted sums, saturation
    // ------------------------------------------------------------------
    logic                   oor7_reg;
    logic signed [SH_W-1:0] sh7_reg [3][2];

    always_ff @(posedge aclk) begin
        if (rdy7) begin
            oor7_reg <= oor6_reg;
            sh7_reg  <= sh6;
        end
    end

    logic [DW-1:0] h7 [3][2];
    logic [5:0]    clip7;
    logic          fits;

    always_comb begin
        for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 2; c++) begin
                // top bits all equal: value fits 32 bits signed
                fits = (&sh7_reg[r][c][SH_W-1:DW-1]) || !(|sh7_reg[r][c][SH_W-1:DW-1]);
                clip7[2*r+c] = !fits;
                if (fits) begin
                    h7[r][c] = sh7_reg[r][c][DW-1:0];
                end else if (sh7_reg[r][c][SH_W-1]) begin
                    h7[r][c] = {1'b1, {(DW-1){1'b0}}};
                end else begin
                    h7[r][c] = {1'b0, {(DW-1){1'b1}}};
                end
                // an out-of-range beat returns all zeros
                if (oor7_reg) begin
                    h7[r][c] = '0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // output register
    // ------------------------------------------------------------------
    logic [DW-1:0] ho_reg [3][2];
    logic          sat_o_reg, oor_o_reg;

    always_ff @(posedge aclk) begin
        if (rdyo) begin
            ho_reg    <= h7;
            sat_o_reg <= (|clip7) && !oor7_reg;
            oor_o_reg <= oor7_reg;
        end
    end

    assign m_hx_re        = ho_reg[0][0];
    assign m_hx_im        = ho_reg[0][1];
    assign m_hy_re        = ho_reg[1][0];
    assign m_hy_im        = ho_reg[1][1];
    assign m_hz_re        = ho_reg[2][0];
    assign m_hz_im        = ho_reg[2][1];
    assign m_saturated    = sat_o_reg;
    assign m_out_of_range = oor_o_reg;

    // ------------------------------------------------------------------
    // valid bits; loads drop out after the store access
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
            v7_reg <= 1'b0;
            vo_reg <= 1'b0;
        end else begin
            if (rdy1) v1_reg <= s_valid;
            if (rdy2) v2_reg <= v1_reg;
            if (rdy3) v3_reg <= v2_reg;
            if (rdy4) v4_reg <= v3_reg && is_mul3;
            if (rdy5) v5_reg <= v4_reg;
            if (rdy6) v6_reg <= v5_reg;
            if (rdy7) v7_reg <= v6_reg;
            if (rdyo) vo_reg <= v7_reg;
        end
    end

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    a_no_backpressure_leak: assert property (@(posedge aclk) disable iff (!aresetn)
        m_ready |-> s_ready)
        else $error("input stalled while output side is ready");

    a_oor_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_out_of_range) |->
            (m_hx_re == '0) && (m_hx_im == '0) && (m_hy_re == '0) &&
            (m_hy_im == '0) && (m_hz_re == '0) && (m_hz_im == '0) && !m_saturated)
        else $error("out-of-range result carries data");

    a_store_rw_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        !((|ram_we) && ram_re))
        else $error("kernel store written and read in the same cycle");

    a_one_lane_write: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0(ram_we))
        else $error("load wrote more than one component lane");

    a_stall_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (v7_reg && !rdy7) |=> (v7_reg && $stable(sh7_reg[0][0]) && $stable(oor7_reg)))
        else $error("stalled sum stage changed");

endmodule

`default_nettype wire
